FILE: sv/rpc_pkg.sv
// Shared types and constants for the relation property checker.
`default_nettype none

package rpc_pkg;

    localparam int MAX_SET = 16;
    localparam int IDX_W   = $clog2(MAX_SET);
    localparam int CNT_W   = $clog2(MAX_SET + 1);
    localparam int VALUE_W = 32;
    localparam int SIZE_W  = 5;
    localparam int INDEX_W = 4;

    typedef logic [MAX_SET-1:0] row_t;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_ADD   = 2'd2,
        OP_EVAL  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_EV_ROW,
        ST_EV_ROWW,
        ST_EV_COL,
        ST_RESULT
    } state_t;

    typedef struct packed {
        op_t                op;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] first;
        logic [VALUE_W-1:0] second;
    } req_t;

    typedef struct packed {
        logic pair_rejected;
        logic reflexive;
        logic symmetric;
        logic antisymmetric;
        logic transitive;
        logic equivalence;
        logic partial_order;
    } result_t;

    typedef struct packed {
        logic idle;
        logic done;
    } status_t;

endpackage

`default_nettype wire

FILE: sv/rpc_engine.sv
// Sequencer with element table and relation row memories.
`default_nettype none

module rpc_engine
    import rpc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire req_t             req,
    input  wire logic [CNT_W-1:0] n,
    input  wire logic             res_ready,
    output status_t               status,
    output result_t               result
);

    logic [VALUE_W-1:0] elem_mem [MAX_SET];
    row_t               row_mem  [MAX_SET];

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [VALUE_W-1:0] v1_reg, v1_next;
    logic [VALUE_W-1:0] v2_reg, v2_next;
    logic [CNT_W-1:0]   cnt_i_reg, cnt_i_next;
    logic [CNT_W-1:0]   cnt_j_reg, cnt_j_next;
    logic               hit_x_reg, hit_x_next;
    logic               hit_y_reg, hit_y_next;
    logic [IDX_W-1:0]   x_reg, x_next;
    logic [IDX_W-1:0]   y_reg, y_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   tag_reg, tag_next;
    row_t               row_i_reg, row_i_next;
    logic               refl_reg, refl_next;
    logic               sym_reg, sym_next;
    logic               anti_reg, anti_next;
    logic               trans_reg, trans_next;
    row_t               row_valid_reg;

    logic [VALUE_W-1:0] elem_rd_reg;
    row_t               row_rd_reg;
    logic               row_rd_ok_reg;

    logic               elem_we;
    logic [IDX_W-1:0]   elem_waddr;
    logic               elem_rd_en;
    logic [IDX_W-1:0]   elem_raddr;
    logic               row_rd_en;
    logic               row_we;
    logic [IDX_W-1:0]   row_addr;
    row_t               row_wdata;
    logic               clear_rows;
    row_t               row_eff;
    row_t               mask;
    logic [IDX_W-1:0]   cur_i;
    logic               ev_a;
    logic               ev_b;

    assign row_eff = row_rd_ok_reg ? row_rd_reg : '0;
    assign mask    = ~({MAX_SET{1'b1}} << n);
    assign cur_i   = cnt_i_reg[IDX_W-1:0];
    assign ev_a    = row_i_reg[tag_reg];
    assign ev_b    = row_eff[cur_i];
    assign status  = '{idle: (state_reg == ST_IDLE), done: (state_reg == ST_RESULT)};

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        v1_next    = v1_reg;
        v2_next    = v2_reg;
        cnt_i_next = cnt_i_reg;
        cnt_j_next = cnt_j_reg;
        hit_x_next = hit_x_reg;
        hit_y_next = hit_y_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        pend_next  = 1'b0;
        tag_next   = tag_reg;
        row_i_next = row_i_reg;
        refl_next  = refl_reg;
        sym_next   = sym_reg;
        anti_next  = anti_reg;
        trans_next = trans_reg;
        elem_we    = 1'b0;
        elem_waddr = req.index[IDX_W-1:0];
        elem_rd_en = 1'b0;
        elem_raddr = cur_i;
        row_rd_en  = 1'b0;
        row_we     = 1'b0;
        row_addr   = cur_i;
        row_wdata  = row_eff | (row_t'(1) << y_reg);
        clear_rows = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next = req.op;
                    v1_next = req.first;
                    v2_next = req.second;
                    case (req.op)
                        OP_CLEAR:
                        begin
                            clear_rows = 1'b1;
                            state_next = ST_RESULT;
                        end
                        OP_LOAD:
                        begin
                            elem_we    = (32'(req.index) < 32'(MAX_SET));
                            state_next = ST_RESULT;
                        end
                        OP_ADD:
                        begin
                            cnt_i_next = '0;
                            hit_x_next = 1'b0;
                            hit_y_next = 1'b0;
                            state_next = ST_LOOKUP;
                        end
                        OP_EVAL:
                        begin
                            cnt_i_next = '0;
                            refl_next  = 1'b1;
                            sym_next   = 1'b1;
                            anti_next  = 1'b1;
                            trans_next = 1'b1;
                            state_next = (n == '0) ? ST_RESULT : ST_EV_ROW;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                if (pend_reg)
                begin
                    if (!hit_x_reg && elem_rd_reg == v1_reg)
                    begin
                        hit_x_next = 1'b1;
                        x_next     = tag_reg;
                    end
                    if (!hit_y_reg && elem_rd_reg == v2_reg)
                    begin
                        hit_y_next = 1'b1;
                        y_next     = tag_reg;
                    end
                end
                if (cnt_i_reg < n)
                begin
                    elem_rd_en = 1'b1;
                    pend_next  = 1'b1;
                    tag_next   = cur_i;
                    cnt_i_next = cnt_i_reg + CNT_W'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = ST_ADD_RD;
                end
            end
            ST_ADD_RD:
            begin
                if (hit_x_reg && hit_y_reg)
                begin
                    row_rd_en  = 1'b1;
                    row_addr   = x_reg;
                    state_next = ST_ADD_WR;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_ADD_WR:
            begin
                row_we     = 1'b1;
                row_addr   = x_reg;
                state_next = ST_RESULT;
            end
            ST_EV_ROW:
            begin
                row_rd_en  = 1'b1;
                state_next = ST_EV_ROWW;
            end
            ST_EV_ROWW:
            begin
                row_i_next = row_eff & mask;
                if (!row_eff[cur_i])
                begin
                    refl_next = 1'b0;
                end
                cnt_j_next = '0;
                state_next = ST_EV_COL;
            end
            ST_EV_COL:
            begin
                if (pend_reg)
                begin
                    if (ev_a != ev_b)
                    begin
                        sym_next = 1'b0;
                    end
                    if (tag_reg != cur_i && ev_a && ev_b)
                    begin
                        anti_next = 1'b0;
                    end
                    if (ev_a && ((row_eff & mask & ~row_i_reg) != '0))
                    begin
                        trans_next = 1'b0;
                    end
                end
                if (cnt_j_reg < n)
                begin
                    row_rd_en  = 1'b1;
                    row_addr   = cnt_j_reg[IDX_W-1:0];
                    pend_next  = 1'b1;
                    tag_next   = cnt_j_reg[IDX_W-1:0];
                    cnt_j_next = cnt_j_reg + CNT_W'(1);
                end
                else if (!pend_reg)
                begin
                    if (cnt_i_reg + CNT_W'(1) == n)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        cnt_i_next = cnt_i_reg + CNT_W'(1);
                        state_next = ST_EV_ROW;
                    end
                end
            end
            ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result = '0;
        case (op_reg)
            OP_ADD:
            begin
                result.pair_rejected = !(hit_x_reg && hit_y_reg);
            end
            OP_EVAL:
            begin
                result.reflexive     = refl_reg;
                result.symmetric     = sym_reg;
                result.antisymmetric = anti_reg;
                result.transitive    = trans_reg;
                result.equivalence   = refl_reg && sym_reg && trans_reg;
                result.partial_order = refl_reg && anti_reg && trans_reg;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_CLEAR;
            pend_reg      <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            pend_reg  <= pend_next;
            if (clear_rows)
            begin
                row_valid_reg <= '0;
            end
            else if (row_we)
            begin
                row_valid_reg[row_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v1_reg    <= v1_next;
        v2_reg    <= v2_next;
        cnt_i_reg <= cnt_i_next;
        cnt_j_reg <= cnt_j_next;
        hit_x_reg <= hit_x_next;
        hit_y_reg <= hit_y_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        tag_reg   <= tag_next;
        row_i_reg <= row_i_next;
        refl_reg  <= refl_next;
        sym_reg   <= sym_next;
        anti_reg  <= anti_next;
        trans_reg <= trans_next;
    end

    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[elem_waddr] <= req.first;
        end
        if (elem_rd_en)
        begin
            elem_rd_reg <= elem_mem[elem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_addr] <= row_wdata;
        end
        if (row_rd_en)
        begin
            row_rd_reg    <= row_mem[row_addr];
            row_rd_ok_reg <= row_valid_reg[row_addr];
        end
    end

`ifndef SYNTH
    a_add_needs_hits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ADD_WR |-> (hit_x_reg && hit_y_reg))
        else $error("row write without both lookups hitting");

    a_pend_states: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_LOOKUP || state_reg == ST_EV_COL))
        else $error("read pending outside a scan state");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EV_COL |-> cnt_i_reg < n)
        else $error("evaluate row counter beyond set size");
`endif

endmodule

`default_nettype wire

FILE: sv/relation_property_checker_top.sv
// Flow, n = active set size: clear and load go straight to the result; add pair scans
// the n table entries, then reads and writes row x (skipped if the pair is rejected);
// evaluate runs states ST_EV_ROW and ST_EV_ROWW, then a column scan, for each row.
// Each scan makes one memory read a cycle, then drains. One transaction in flight; the next
// is accepted the cycle after the result registers.
// Reset clears the matrix through row valid bits and sets set_size to 1, not the table.
`default_nettype none

module relation_property_checker_top
    import rpc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write_en,
    input  wire logic [SIZE_W-1:0]         cfg_write_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [1:0]                operation,
    input  wire logic [INDEX_W-1:0]        element_index,
    input  wire logic signed [VALUE_W-1:0] first_value,
    input  wire logic signed [VALUE_W-1:0] second_value,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           pair_rejected,
    output logic                           is_reflexive,
    output logic                           is_symmetric,
    output logic                           is_antisymmetric,
    output logic                           is_transitive,
    output logic                           is_equivalence,
    output logic                           is_partial_order
);

    logic [SIZE_W-1:0] set_size_reg;
    logic [CNT_W-1:0]  n_active;
    logic              out_valid_reg;
    result_t           out_res_reg;
    logic              start;
    logic              res_ready;
    req_t              req;
    status_t           status;
    result_t           eng_result;

    assign n_active  = (32'(set_size_reg) > 32'(MAX_SET)) ? CNT_W'(MAX_SET)
                                                          : CNT_W'(set_size_reg);
    assign in_stall  = !status.idle;
    assign start     = in_valid && !in_stall;
    assign res_ready = !out_valid_reg || !out_stall;
    assign req       = '{op: op_t'(operation), index: element_index,
                         first: first_value, second: second_value};

    rpc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .n         (n_active),
        .res_ready (res_ready),
        .status    (status),
        .result    (eng_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg  <= SIZE_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                set_size_reg <= cfg_write_data;
            end
            if (status.done && res_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.done && res_ready)
        begin
            out_res_reg <= eng_result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign pair_rejected    = out_res_reg.pair_rejected;
    assign is_reflexive     = out_res_reg.reflexive;
    assign is_symmetric     = out_res_reg.symmetric;
    assign is_antisymmetric = out_res_reg.antisymmetric;
    assign is_transitive    = out_res_reg.transitive;
    assign is_equivalence   = out_res_reg.equivalence;
    assign is_partial_order = out_res_reg.partial_order;

`ifndef SYNTH
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(status.done))
        else $error("result appeared without engine completion");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> in_stall)
        else $error("engine idle right after accepting a transaction");

    a_done_held: assert property (@(posedge clk) disable iff (!rst_n)
        (status.done && !res_ready) |=> status.done)
        else $error("completed result dropped while output was full");
`endif

endmodule

`default_nettype wire

FILE: test/relation_property_checker_top_tb.sv
// Self-checking testbench for relation_property_checker_top with a predictor of the relation matrix.
module relation_property_checker_top_tb;
    import rpc_pkg::*;

    localparam logic [VALUE_W-1:0] VALUE_MIN      = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VALUE_MAX      = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_ZERO     = 32'h0000_0000;
    localparam logic [VALUE_W-1:0] VALUE_PATTERN  = 32'hA5A5_A5A5;
    localparam int ITEM_TARGET = 1650;
    localparam int HOLD_CYCLES = 200;
    localparam int END_CYCLES  = 400;
    localparam int TIMEOUT     = 6_000_000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_write_en;
    logic [SIZE_W-1:0]   cfg_write_data;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          operation;
    logic [INDEX_W-1:0]  element_index;
    logic [VALUE_W-1:0]  first_value;
    logic [VALUE_W-1:0]  second_value;
    logic                out_valid;
    logic                out_stall;
    logic                pair_rejected;
    logic                is_reflexive;
    logic                is_symmetric;
    logic                is_antisymmetric;
    logic                is_transitive;
    logic                is_equivalence;
    logic                is_partial_order;

    // predictor state
    logic [SIZE_W-1:0]   size_setting;
    row_t                relation_bits [MAX_SET];
    logic [VALUE_W-1:0]  element_values [MAX_SET];
    result_t             expected_outcomes [$];

    bit idle_enable;
    int hold_requests;
    int holds_done;
    int error_count;
    int items_sent;
    int results_checked;
    int evaluations;
    int pairs_rejected;
    int equivalences_seen;
    int partial_orders_seen;
    int size_writes;

    relation_property_checker_top u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .element_index    (element_index),
        .first_value      (first_value),
        .second_value     (second_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .pair_rejected    (pair_rejected),
        .is_reflexive     (is_reflexive),
        .is_symmetric     (is_symmetric),
        .is_antisymmetric (is_antisymmetric),
        .is_transitive    (is_transitive),
        .is_equivalence   (is_equivalence),
        .is_partial_order (is_partial_order)
    );

    always #1 clk = ~clk;

    function automatic int active_size();
        return (size_setting > MAX_SET) ? MAX_SET : int'(size_setting);
    endfunction

    function automatic int find_element(logic [VALUE_W-1:0] value, int n);
        for (int k = 0; k < n; k++)
            if (element_values[k] == value)
                return k;
        return -1;
    endfunction

    function automatic result_t relation_outcome(op_t op, logic [INDEX_W-1:0] idx,
                                                 logic [VALUE_W-1:0] a,
                                                 logic [VALUE_W-1:0] b);
        result_t r;
        int      n;
        int      x;
        int      y;
        row_t    mask;
        logic    refl;
        logic    sym;
        logic    anti;
        logic    trans;
        r = '0;
        n = active_size();
        mask = (n >= MAX_SET) ? '1 : row_t'((32'd1 << n) - 32'd1);
        case (op)
            OP_CLEAR:
                for (int i = 0; i < MAX_SET; i++)
                    relation_bits[i] = '0;
            OP_LOAD:
                element_values[idx] = a;
            OP_ADD:
            begin
                x = find_element(a, n);
                y = find_element(b, n);
                if (x < 0 || y < 0)
                    r.pair_rejected = 1'b1;
                else
                    relation_bits[x][y] = 1'b1;
            end
            default:
            begin
                refl  = 1'b1;
                sym   = 1'b1;
                anti  = 1'b1;
                trans = 1'b1;
                for (int i = 0; i < n; i++)
                begin
                    if (!relation_bits[i][i])
                        refl = 1'b0;
                    for (int j = 0; j < n; j++)
                    begin
                        if (relation_bits[i][j] != relation_bits[j][i])
                            sym = 1'b0;
                        if (i != j && relation_bits[i][j] && relation_bits[j][i])
                            anti = 1'b0;
                        if (relation_bits[i][j] &&
                            ((relation_bits[j] & mask & ~relation_bits[i]) != '0))
                            trans = 1'b0;
                    end
                end
                r.reflexive     = refl;
                r.symmetric     = sym;
                r.antisymmetric = anti;
                r.transitive    = trans;
                r.equivalence   = refl & sym & trans;
                r.partial_order = refl & anti & trans;
            end
        endcase
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_set_size();
        case ($urandom_range(0, 11))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd16;
            3:       return 5'd31;
            4:       return SIZE_W'($urandom_range(17, 30));
            5, 6:    return SIZE_W'($urandom_range(7, 15));
            default: return SIZE_W'($urandom_range(2, 6));
        endcase
    endfunction

    // valid stays high across back-to-back transactions; it drops for a gap or while waiting for results
    task automatic send_item(op_t op, logic [INDEX_W-1:0] idx,
                             logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b);
        int      gap;
        result_t exp;
        gap = idle_enable ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= op;
        element_index <= idx;
        first_value   <= a;
        second_value  <= b;
        do @(posedge clk); while (in_stall !== 1'b0);
        exp = relation_outcome(op, idx, a, b);
        expected_outcomes.push_back(exp);
        items_sent++;
        if (exp.pair_rejected)
            pairs_rejected++;
        if (op == OP_EVAL)
        begin
            evaluations++;
            if (exp.equivalence)
                equivalences_seen++;
            if (exp.partial_order)
                partial_orders_seen++;
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_outcomes.size() != 0);
    endtask

    task automatic write_set_size(logic [SIZE_W-1:0] value);
        wait_for_results();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        size_setting = value;
        size_writes++;
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_item(OP_ADD, INDEX_W'($urandom_range(0, 15)), $urandom, $urandom);
            1: send_item(OP_ADD, INDEX_W'($urandom_range(0, 15)),
                         element_values[$urandom_range(0, MAX_SET - 1)], $urandom);
            2: send_item(OP_LOAD, INDEX_W'($urandom_range(0, 15)), $urandom, $urandom);
            default: send_item(OP_EVAL, INDEX_W'($urandom_range(0, 15)), $urandom, $urandom);
        endcase
    endtask

    task automatic reload_elements();
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] step;
        base = $urandom;
        step = $urandom | 32'd1;
        for (int k = 0; k < active_size(); k++)
            send_item(OP_LOAD, INDEX_W'(k), base + k * step, $urandom);
    endtask

    // build a shaped relation, usually from a cleared matrix, sometimes with one bit flipped
    task automatic run_relation_round();
        row_t want [MAX_SET];
        int   group [MAX_SET];
        int   n;
        int   shape;
        int   ri;
        int   rj;
        n = active_size();
        shape = $urandom_range(0, 4);
        for (int i = 0; i < MAX_SET; i++)
        begin
            want[i]  = '0;
            group[i] = $urandom_range(0, 2);
        end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                case (shape)
                    0:       want[i][j] = (group[i] == group[j]);
                    1:       want[i][j] = (i <= j);
                    2:       want[i][j] = ((i & j) == i);
                    3:       want[i][j] = ($urandom_range(0, 3) == 0);
                    default: want[i][j] = (i == j) || (i == j + 1) || (j == i + 1);
                endcase
        if (n > 0 && $urandom_range(0, 3) == 0)
        begin
            ri = $urandom_range(0, n - 1);
            rj = $urandom_range(0, n - 1);
            want[ri][rj] = !want[ri][rj];
        end
        if ($urandom_range(0, 7) != 0)
            send_item(OP_CLEAR, INDEX_W'($urandom_range(0, 15)), $urandom, $urandom);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (want[i][j])
                begin
                    if ($urandom_range(0, 11) == 0)
                        send_noise();
                    send_item(OP_ADD, INDEX_W'($urandom_range(0, 15)), element_values[i],
                              element_values[j]);
                end
        send_item(OP_EVAL, INDEX_W'($urandom_range(0, 15)), $urandom, $urandom);
    endtask

    task automatic test_reset_state();
        send_item(OP_EVAL, 4'd0, VALUE_ZERO, VALUE_ZERO);
    endtask

    task automatic test_element_load();
        write_set_size(5'd4);
        send_item(OP_LOAD, 4'd0, VALUE_MIN, VALUE_MAX);
        send_item(OP_LOAD, 4'd1, VALUE_MAX, VALUE_MIN);
        send_item(OP_LOAD, 4'd2, VALUE_ALL_ONES, VALUE_ZERO);
        send_item(OP_LOAD, 4'd3, VALUE_ZERO, VALUE_ALL_ONES);
        send_item(OP_LOAD, 4'd15, VALUE_PATTERN, VALUE_ZERO);
    endtask

    task automatic test_pair_add();
        send_item(OP_ADD, 4'd15, VALUE_MIN, VALUE_MAX);
        send_item(OP_ADD, 4'd0, VALUE_ALL_ONES, VALUE_ALL_ONES);
        send_item(OP_ADD, 4'd0, VALUE_MAX, VALUE_PATTERN);
        send_item(OP_ADD, 4'd0, 32'd5, VALUE_ZERO);
        send_item(OP_ADD, 4'd0, VALUE_MIN, VALUE_MAX);
    endtask

    task automatic test_size_shrink();
        send_item(OP_EVAL, 4'd0, VALUE_ZERO, VALUE_ZERO);
        write_set_size(5'd2);
        send_item(OP_EVAL, 4'd0, VALUE_ZERO, VALUE_ZERO);
        write_set_size(5'd4);
    endtask

    task automatic test_duplicate_values();
        send_item(OP_LOAD, 4'd3, VALUE_ALL_ONES, VALUE_ZERO);
        send_item(OP_ADD, 4'd0, VALUE_ALL_ONES, VALUE_MIN);
        send_item(OP_EVAL, 4'd0, VALUE_ZERO, VALUE_ZERO);
    endtask

    task automatic test_clear();
        send_item(OP_CLEAR, 4'd0, VALUE_ZERO, VALUE_ZERO);
        send_item(OP_EVAL, 4'd0, VALUE_ZERO, VALUE_ZERO);
    endtask

    task automatic test_empty_set();
        write_set_size(5'd0);
        send_item(OP_ADD, 4'd0, VALUE_MIN, VALUE_MIN);
        send_item(OP_EVAL, 4'd0, VALUE_ZERO, VALUE_ZERO);
    endtask

    task automatic test_output_hold();
        hold_requests++;
        for (int k = 0; k < 6; k++)
            send_item((k % 2) ? OP_EVAL : OP_ADD, INDEX_W'($urandom_range(0, 15)),
                      element_values[$urandom_range(0, MAX_SET - 1)],
                      element_values[$urandom_range(0, MAX_SET - 1)]);
        wait_for_results();
    endtask

    task automatic test_random_relations();
        for (int k = 0; k < MAX_SET; k++)
            send_item(OP_LOAD, INDEX_W'(k), $urandom, $urandom);
        write_set_size(5'd31);
        run_relation_round();
        test_output_hold();
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 3) == 0)
                write_set_size(pick_set_size());
            if ($urandom_range(0, 3) == 0)
                reload_elements();
            if ($urandom_range(0, 7) == 0)
                idle_enable = !idle_enable;
            run_relation_round();
        end
        idle_enable = 1'b1;
    endtask

    // receiver: optional long hold, then a random stall per result
    initial
    begin : result_sink
        int pause;
        forever
        begin
            if (hold_requests != holds_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            pause = idle_enable ? $urandom_range(0, 10) : 0;
            out_stall <= (pause != 0);
            do @(posedge clk); while (out_valid !== 1'b1);
            if (pause > 0)
            begin
                repeat (pause - 1) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    task automatic check_field(string name, logic exp, logic got);
        if (got !== exp)
        begin
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, exp, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t exp;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual %b", $time,
                         {pair_rejected, is_reflexive, is_symmetric, is_antisymmetric,
                          is_transitive, is_equivalence, is_partial_order});
                error_count++;
            end
            else
            begin
                exp = expected_outcomes.pop_front();
                results_checked++;
                check_field("pair_rejected", exp.pair_rejected, pair_rejected);
                check_field("is_reflexive", exp.reflexive, is_reflexive);
                check_field("is_symmetric", exp.symmetric, is_symmetric);
                check_field("is_antisymmetric", exp.antisymmetric, is_antisymmetric);
                check_field("is_transitive", exp.transitive, is_transitive);
                check_field("is_equivalence", exp.equivalence, is_equivalence);
                check_field("is_partial_order", exp.partial_order, is_partial_order);
            end
        end
    end

    initial
    begin
        #(TIMEOUT);
        $display("Timeout with %0d transactions outstanding", expected_outcomes.size());
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        operation      = OP_CLEAR;
        element_index  = '0;
        first_value    = '0;
        second_value   = '0;
        size_setting   = 5'd1;
        for (int i = 0; i < MAX_SET; i++)
            relation_bits[i] = '0;
        idle_enable = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_element_load();
        test_pair_add();
        test_size_shrink();
        test_duplicate_values();
        test_clear();
        test_empty_set();
        test_random_relations();

        wait_for_results();
        repeat (END_CYCLES) @(posedge clk);
        $display("Ran %0d transactions, %0d results checked, %0d set_size writes",
                 items_sent, results_checked, size_writes);
        $display("%0d evaluations (%0d equivalences, %0d partial orders), %0d pairs rejected",
                 evaluations, equivalences_seen, partial_orders_seen, pairs_rejected);
        if (error_count == 0 && expected_outcomes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
